// ===== src/cbpe_pkg.sv =====
// Shared types, constants and the control-store program for the closed Bezier path evaluator.
`default_nettype none

package cbpe_pkg;

  // Table size and number format.
  localparam int MAX_POINTS = 64;
  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 24;
  localparam int PARAM_W    = 22;
  localparam int INT_W      = PARAM_W - FRAC_BITS;
  localparam int PTR_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DIVC_W     = $clog2(INT_W + 1);
  localparam int POINT_W    = 3 * COORD_W;

  // Blend arithmetic: difference, product and its integer part.
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = DIFF_W + FRAC_BITS + 1;
  localparam int HI_W       = PROD_W - FRAC_BITS;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

  // Stream port widths.
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = ((POINT_W + PARAM_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((POINT_W + CNT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - POINT_W - CNT_W;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_EVAL   = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } point_t;

  // Microprogram.
  localparam int UPC_W = 5;

  typedef enum logic [1:0] {
    FIN_NONE  = 2'd0,
    FIN_EVAL  = 2'd1,
    FIN_OTHER = 2'd2
  } fin_t;

  typedef enum logic [1:0] {
    JMP_NEXT     = 2'd0,
    JMP_NOT_EVAL = 2'd1,
    JMP_DIV_LOOP = 2'd2
  } jmp_t;

  typedef struct packed {
    logic             div;      // one remainder step of segment modulo count
    logic             set_idx;  // index register takes the remainder
    logic             rd;       // read the table at the index register
    logic             inc;      // index advances, wrapping at the count
    logic             sh;       // operand registers shift, new value enters at the tail
    logic             src_ram;  // shifted-in value comes from the table, else the blend
    logic             mul;      // blend product of the two head operands
    fin_t             fin;      // last step: result is registered
    jmp_t             jmp;
    logic [UPC_W-1:0] target;
  } uword_t;

  localparam logic [UPC_W-1:0] UA_ENTRY = 5'd0;
  localparam logic [UPC_W-1:0] UA_DIV   = 5'd1;
  localparam logic [UPC_W-1:0] UA_OTHER = 5'd24;

  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] addr);
    uword_t w;
    w = '0;
    case (addr)
      5'd0: begin
        w.jmp    = JMP_NOT_EVAL;
        w.target = UA_OTHER;
      end
      5'd1: begin
        w.div    = 1'b1;
        w.jmp    = JMP_DIV_LOOP;
        w.target = UA_DIV;
      end
      5'd2: begin
        w.set_idx = 1'b1;
      end
      5'd3: begin
        w.rd  = 1'b1;
        w.inc = 1'b1;
      end
      5'd4, 5'd5: begin
        w.rd      = 1'b1;
        w.inc     = 1'b1;
        w.sh      = 1'b1;
        w.src_ram = 1'b1;
      end
      5'd6: begin
        w.rd      = 1'b1;
        w.sh      = 1'b1;
        w.src_ram = 1'b1;
      end
      5'd7: begin
        w.sh      = 1'b1;
        w.src_ram = 1'b1;
      end
      5'd8, 5'd10, 5'd12, 5'd15, 5'd17, 5'd21: begin
        w.mul = 1'b1;
      end
      5'd9, 5'd11, 5'd13, 5'd14, 5'd16, 5'd18, 5'd19, 5'd20, 5'd22: begin
        w.sh = 1'b1;
      end
      5'd23: begin
        w.fin = FIN_EVAL;
      end
      default: begin
        w.fin = FIN_OTHER;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== src/cbpe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cbpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/cyclic_bezier_path_eval.sv =====
// Top level of the closed cubic Bezier path evaluator, run by a microcoded sequencer.
// An evaluation runs the remainder steps, the table reads and the blends before its
// finishing step registers the result; append, clear and failed evaluations go straight
// to the finishing step. One item at a time: s_axis_tready rises with the registered
// result. One microprogram step runs per cycle, but the finishing step waits while the
// previous result is not taken. Reset (rst, synchronous) empties table and result.
`default_nettype none

module cyclic_bezier_path_eval (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata, lowest bit up: point_x[23:0], point_y[47:24], point_z[71:48],
  // path_param[93:72], zero pad[95:94].
  input  logic [cbpe_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: operation[1:0].
  input  logic [cbpe_pkg::OP_W-1:0]          s_axis_tuser,
  // Result stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata, lowest bit up: pos_x[23:0], pos_y[47:24], pos_z[71:48],
  // point_count[78:72], zero pad[79].
  output logic [cbpe_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // tuser: status[1:0].
  output logic [cbpe_pkg::STATUS_W-1:0]      m_axis_tuser
);

  // ---------------------------------------------------------------------------
  // Sequencer state. The program counter walks the control store; each word
  // drives the datapath while it is current. Step 0 branches non-evaluations (and
  // evaluations of an empty table) straight to the finishing step.
  // ---------------------------------------------------------------------------
  logic                          busy;
  logic [cbpe_pkg::UPC_W-1:0]    upc;
  cbpe_pkg::uword_t              uw;
  logic                          take;
  logic                          stall;
  logic                          adv;
  logic                          accept;

  // Latched transaction.
  logic [cbpe_pkg::OP_W-1:0]     op;
  logic [cbpe_pkg::INT_W-1:0]    seg_bits;
  logic [cbpe_pkg::FRAC_BITS-1:0] frac;
  cbpe_pkg::point_t              new_pt;

  // Table fill count.
  logic [cbpe_pkg::CNT_W-1:0]    count;
  logic [cbpe_pkg::CNT_W-1:0]    count_next;
  logic [cbpe_pkg::PTR_W:0]      count_ext;

  // Segment index: restoring remainder, one bit of the integer part per step.
  logic [cbpe_pkg::PTR_W-1:0]    rem;
  logic [cbpe_pkg::PTR_W-1:0]    rem_next;
  logic [cbpe_pkg::PTR_W:0]      trial;
  logic [cbpe_pkg::DIVC_W-1:0]   divcnt;
  logic [cbpe_pkg::PTR_W-1:0]    idx;
  logic [cbpe_pkg::PTR_W-1:0]    idx_inc;
  logic [cbpe_pkg::PTR_W:0]      idx_plus;

  // Table.
  logic                          tbl_we;
  logic [cbpe_pkg::POINT_W-1:0]  tbl_rdata;
  cbpe_pkg::point_t              rd_pt;

  // Operand queue for De Casteljau: four points, blends always take the two at
  // the head and push their result onto the tail. Plain shifts drop the head
  // operand that the next level no longer needs.
  cbpe_pkg::coord_t              pc [4][3];
  cbpe_pkg::coord_t              shift_in [3];
  cbpe_pkg::coord_t              blend [3];
  logic signed [cbpe_pkg::PROD_W-1:0] prod [3];
  logic signed [cbpe_pkg::PROD_W-1:0] prod_next [3];
  logic signed [cbpe_pkg::DIFF_W-1:0] diff [3];
  logic signed [cbpe_pkg::HI_W-1:0]   blend_w [3];
  logic signed [cbpe_pkg::FRAC_BITS:0] t_s;

  // Result fields for the finishing step.
  logic [cbpe_pkg::STATUS_W-1:0] status_next;
  logic                          room;

  assign uw            = cbpe_pkg::ucode_rom(upc);
  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // A finishing step waits while the previous result has not been taken.
  assign stall = (uw.fin != cbpe_pkg::FIN_NONE) && m_axis_tvalid && !m_axis_tready;
  assign adv   = busy && !stall;

  assign count_ext = (cbpe_pkg::PTR_W + 1)'(count);
  assign room      = count < cbpe_pkg::CNT_W'(cbpe_pkg::MAX_POINTS);

  always_comb begin
    case (uw.jmp)
      cbpe_pkg::JMP_NOT_EVAL: take = (op != cbpe_pkg::OP_EVAL) || (count == '0);
      cbpe_pkg::JMP_DIV_LOOP: take = divcnt != cbpe_pkg::DIVC_W'(1);
      default:                take = 1'b0;
    endcase
  end

  // Remainder step: shift in the next bit of the integer part, subtract the
  // count when it fits. The remainder stays below the count, so it fits in PTR_W bits.
  assign trial    = {rem, seg_bits[cbpe_pkg::INT_W-1]};
  assign rem_next = (trial >= count_ext) ? cbpe_pkg::PTR_W'(trial - count_ext)
                                         : cbpe_pkg::PTR_W'(trial);

  // Next control point index, wrapping to zero at the count.
  assign idx_plus = {1'b0, idx} + (cbpe_pkg::PTR_W + 1)'(1);
  assign idx_inc  = (idx_plus == count_ext) ? '0 : idx_plus[cbpe_pkg::PTR_W-1:0];

  // Append writes at the fill count when there is room.
  assign tbl_we = adv && (uw.fin == cbpe_pkg::FIN_OTHER) && (op == cbpe_pkg::OP_APPEND) && room;

  cbpe_ram #(
    .WIDTH(cbpe_pkg::POINT_W),
    .DEPTH(cbpe_pkg::MAX_POINTS)
  ) u_ram (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(count[cbpe_pkg::PTR_W-1:0]),
    .wdata(new_pt),
    .re   (adv && uw.rd),
    .raddr(idx),
    .rdata(tbl_rdata)
  );

  assign rd_pt = tbl_rdata;

  // Blend unit, one lane per axis. The multiply step registers
  // (b - a) * t + 1/2; the following step adds the floor of that to a, which
  // rounds exact halves toward plus infinity.
  assign t_s = $signed({1'b0, frac});

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a]      = cbpe_pkg::DIFF_W'(pc[1][a]) - cbpe_pkg::DIFF_W'(pc[0][a]);
      prod_next[a] = diff[a] * t_s + $signed(cbpe_pkg::ROUND_HALF);
      blend_w[a]   = cbpe_pkg::HI_W'(pc[0][a])
                   + $signed(prod[a][cbpe_pkg::PROD_W-1:cbpe_pkg::FRAC_BITS]);
      blend[a]     = blend_w[a][cbpe_pkg::COORD_W-1:0];
    end
    shift_in[0] = uw.src_ram ? rd_pt.x : blend[0];
    shift_in[1] = uw.src_ram ? rd_pt.y : blend[1];
    shift_in[2] = uw.src_ram ? rd_pt.z : blend[2];
  end

  // Count and status after the item.
  always_comb begin
    count_next  = count;
    status_next = cbpe_pkg::STATUS_OK;
    if (uw.fin == cbpe_pkg::FIN_OTHER) begin
      case (op)
        cbpe_pkg::OP_APPEND: begin
          if (room) begin
            count_next = count + cbpe_pkg::CNT_W'(1);
          end else begin
            status_next = cbpe_pkg::STATUS_FULL;
          end
        end
        cbpe_pkg::OP_CLEAR: begin
          count_next = '0;
        end
        cbpe_pkg::OP_EVAL: begin
          status_next = cbpe_pkg::STATUS_EMPTY;
        end
        default: begin
          status_next = cbpe_pkg::STATUS_OK;
        end
      endcase
    end
  end

  // Control registers. The result stays valid until taken; a finishing step
  // only runs once the previous result is gone or is taken at the same edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      upc           <= cbpe_pkg::UA_ENTRY;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      m_axis_tvalid <= (m_axis_tvalid && !m_axis_tready)
                    || (adv && (uw.fin != cbpe_pkg::FIN_NONE));
      if (accept) begin
        busy <= 1'b1;
        upc  <= cbpe_pkg::UA_ENTRY;
      end else if (adv) begin
        if (uw.fin != cbpe_pkg::FIN_NONE) begin
          busy  <= 1'b0;
          count <= count_next;
        end else begin
          upc <= take ? uw.target : upc + cbpe_pkg::UPC_W'(1);
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= s_axis_tuser;
      new_pt.x <= s_axis_tdata[0 +: cbpe_pkg::COORD_W];
      new_pt.y <= s_axis_tdata[cbpe_pkg::COORD_W +: cbpe_pkg::COORD_W];
      new_pt.z <= s_axis_tdata[2*cbpe_pkg::COORD_W +: cbpe_pkg::COORD_W];
      seg_bits <= s_axis_tdata[cbpe_pkg::POINT_W + cbpe_pkg::FRAC_BITS +: cbpe_pkg::INT_W];
      frac     <= s_axis_tdata[cbpe_pkg::POINT_W +: cbpe_pkg::FRAC_BITS];
      rem      <= '0;
      divcnt   <= cbpe_pkg::DIVC_W'(cbpe_pkg::INT_W);
    end else if (adv) begin
      if (uw.div) begin
        rem      <= rem_next;
        seg_bits <= seg_bits << 1;
        divcnt   <= divcnt - cbpe_pkg::DIVC_W'(1);
      end
      if (uw.set_idx) begin
        idx <= rem;
      end
      if (uw.inc) begin
        idx <= idx_inc;
      end
      if (uw.mul) begin
        for (int a = 0; a < 3; a++) begin
          prod[a] <= prod_next[a];
        end
      end
      if (uw.sh) begin
        for (int a = 0; a < 3; a++) begin
          for (int k = 0; k < 3; k++) begin
            pc[k][a] <= pc[k+1][a];
          end
          pc[3][a] <= shift_in[a];
        end
      end
      if (uw.fin == cbpe_pkg::FIN_EVAL) begin
        m_axis_tdata <= {cbpe_pkg::OUT_PAD_W'(0), count_next, pc[3][2], pc[3][1], pc[3][0]};
        m_axis_tuser <= cbpe_pkg::STATUS_OK;
      end else if (uw.fin == cbpe_pkg::FIN_OTHER) begin
        m_axis_tdata <= {cbpe_pkg::OUT_PAD_W'(0), count_next, cbpe_pkg::POINT_W'(0)};
        m_axis_tuser <= status_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/cbpe_checker.sv =====
// Port-level assertions for the closed Bezier path evaluator, bound to its top level.
`default_nettype none

module cbpe_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [cbpe_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic [cbpe_pkg::OP_W-1:0]       s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [cbpe_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [cbpe_pkg::STATUS_W-1:0]   m_axis_tuser
);

  logic [cbpe_pkg::CNT_W-1:0] out_count;

  assign out_count = m_axis_tdata[cbpe_pkg::POINT_W +: cbpe_pkg::CNT_W];

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // The block works on one transaction at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  // Failed operations report a zero position.
  a_fail_pos_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != cbpe_pkg::STATUS_OK) |->
      m_axis_tdata[cbpe_pkg::POINT_W-1:0] == '0)
    else $error("position not zero on a failed operation");

  // The reported count never exceeds the table size.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_count <= cbpe_pkg::CNT_W'(cbpe_pkg::MAX_POINTS))
    else $error("point count beyond table size");

  // A full-table status comes only with a full table.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == cbpe_pkg::STATUS_FULL) |->
      out_count == cbpe_pkg::CNT_W'(cbpe_pkg::MAX_POINTS))
    else $error("table-full status with room left");

endmodule

bind cyclic_bezier_path_eval cbpe_checker u_checker (.*);

`default_nettype wire
